// ===== rtl/core/ksd_pkg.sv =====
// Shared types and constants for the keypad scan debounce unit.
`timescale 1ns / 1ps
`default_nettype none

package ksd_pkg;

    localparam int NUM_ROWS_DEF  = 4;
    localparam int NUM_COLS_DEF  = 4;
    localparam int TIME_BITS_DEF = 32;

    localparam int IN_KEYS   = 16;
    localparam int STAMP_W   = 32;
    localparam int TIME_MAXW = 64;

    localparam logic [STAMP_W-1:0] DEBOUNCE_RESET = 32'd50000;

    typedef struct packed {
        logic [IN_KEYS-1:0] column_levels;
        logic [STAMP_W-1:0] now_time;
    } t_scan_item;

    typedef struct packed {
        logic [IN_KEYS-1:0] pressed_mask;
        logic [IN_KEYS-1:0] debounce_pulse;
        logic [IN_KEYS-1:0] new_press;
    } t_result_item;

endpackage

`default_nettype wire

// ===== rtl/core/keypad_scan_debounce_unit.sv =====
// Top level of the keypad scan debounce unit.
`timescale 1ns / 1ps
`default_nettype none

// Scans are taken one per cycle with no gaps while the output does not stall: a scan is
// registered on entry, every key slice compares its elapsed time against the debounce
// time in the next cycle, and the result is registered on the way out, so a result is
// valid once both registers are passed. The longest path is one TIME_BITS-wide subtract
// and compare per key. Only the first sixteen keys (row * NUM_COLS + col) have state;
// further keys never press. Write the debounce time only while no scan is in flight.
module keypad_scan_debounce_unit
    import ksd_pkg::*;
#(
    parameter int NUM_ROWS  = NUM_ROWS_DEF,
    parameter int NUM_COLS  = NUM_COLS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_scan_item         i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_result_item            o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [STAMP_W-1:0] i_cfg_data
);

    localparam int KEY_COUNT = NUM_ROWS * NUM_COLS;
    localparam int SLICES    = (KEY_COUNT < IN_KEYS) ? KEY_COUNT : IN_KEYS;

    logic [STAMP_W-1:0]   r_debounce;
    logic                 w_scan_valid;
    logic                 w_res_stall;
    logic                 w_advance;
    t_scan_item           w_scan;
    t_result_item         w_result;
    logic [TIME_MAXW-1:0] w_now_wide;
    logic [TIME_MAXW-1:0] w_limit_wide;
    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_limit;
    logic [IN_KEYS-1:0]   w_down;
    logic [IN_KEYS-1:0]   w_pulse;
    logic [IN_KEYS-1:0]   w_fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_debounce <= i_cfg_data;
        end
    end

    ksd_pipe_stage #(
        .WIDTH ($bits(t_scan_item))
    ) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_item),
        .o_valid (w_scan_valid),
        .i_stall (w_res_stall),
        .o_data  (w_scan)
    );

    assign w_advance    = w_scan_valid && !w_res_stall;
    assign w_now_wide   = {{(TIME_MAXW - STAMP_W){1'b0}}, w_scan.now_time};
    assign w_limit_wide = {{(TIME_MAXW - STAMP_W){1'b0}}, r_debounce};
    assign w_now        = w_now_wide[TIME_BITS-1:0];
    assign w_limit      = w_limit_wide[TIME_BITS-1:0];

    for (genvar k = 0; k < SLICES; k++) begin : g_key
        assign w_down[k] = !w_scan.column_levels[k];

        ksd_key_slice #(
            .TIME_BITS (TIME_BITS)
        ) u_slice (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_down    (w_down[k]),
            .i_now     (w_now),
            .i_limit   (w_limit),
            .o_fired   (w_pulse[k]),
            .o_fresh   (w_fresh[k])
        );
    end

    if (SLICES < IN_KEYS) begin : g_unused
        assign w_down[IN_KEYS-1:SLICES]  = '0;
        assign w_pulse[IN_KEYS-1:SLICES] = '0;
        assign w_fresh[IN_KEYS-1:SLICES] = '0;
    end

    assign w_result.pressed_mask   = w_down;
    assign w_result.debounce_pulse = w_pulse;
    assign w_result.new_press      = w_fresh;

    ksd_pipe_stage #(
        .WIDTH ($bits(t_result_item))
    ) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_scan_valid),
        .o_stall (w_res_stall),
        .i_data  (w_result),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ksd_pipe_stage.sv =====
// One valid/stall register stage that takes a new item in every unstalled cycle.
`timescale 1ns / 1ps
`default_nettype none

module ksd_pipe_stage #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic      [WIDTH-1:0] o_data
);

    logic             r_valid;
    logic [WIDTH-1:0] r_data;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ksd_key_slice.sv =====
// Per-key debounce state and elapsed-time compare.
`timescale 1ns / 1ps
`default_nettype none

module ksd_key_slice #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_advance,
    input  wire logic                 i_down,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire logic [TIME_BITS-1:0] i_limit,
    output logic                      o_fired,
    output logic                      o_fresh
);

    logic                 r_timing;
    logic                 r_reported;
    logic [TIME_BITS-1:0] r_start;
    logic                 n_timing;
    logic                 n_reported;
    logic [TIME_BITS-1:0] w_elapsed;

    assign w_elapsed  = i_now - r_start;
    assign o_fired    = i_down && r_timing && (w_elapsed >= i_limit);
    assign o_fresh    = o_fired && !r_reported;
    assign n_timing   = i_down && !o_fired;
    assign n_reported = i_down && (r_reported || o_fired);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing   <= 1'b0;
            r_reported <= 1'b0;
        end else if (i_advance) begin
            r_timing   <= n_timing;
            r_reported <= n_reported;
        end
    end

    // start timing on a press, and again after each debounce pulse while the key is held
    always_ff @(posedge i_clk) begin
        if (i_advance && i_down && !r_timing) begin
            r_start <= i_now;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ksd_checker.sv =====
// Port-level checks for the keypad scan debounce unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ksd_checker
    import ksd_pkg::*;
(
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_out_valid,
    input wire logic         i_out_stall,
    input wire t_result_item o_out_item
);

    a_reset_drops_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_pulse_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.debounce_pulse & ~o_out_item.pressed_mask) == '0))
        else $error("debounce pulse on a released key");

    a_new_needs_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.new_press & ~o_out_item.debounce_pulse) == '0))
        else $error("new press without a debounce pulse");

    a_stalled_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result item changed");

endmodule

bind keypad_scan_debounce_unit ksd_checker u_ksd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
